FILE: sv/wio_pkg.sv
// Shared types and constants for the wavetable oscillator core.
// No dependencies; the top level and the checker import this package.
`timescale 1ns / 1ps

package wio_pkg;

   // default storage parameters
   localparam int DEF_TABLE_DEPTH   = 32;
   localparam int DEF_FRACTION_BITS = 16;

   // fixed field widths
   localparam int OP_W         = 1;
   localparam int INDEX_W      = 5;
   localparam int SAMPLE_W     = 16;
   localparam int TABLE_SIZE_W = 6;
   localparam int INC_W        = 21;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 21;

   // request opcodes
   localparam logic [OP_W-1:0] OP_TICK  = 1'b0;
   localparam logic [OP_W-1:0] OP_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_MODE  = 2'd2;

   // register reset values
   localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = 6'd32;
   localparam logic [INC_W-1:0]        PHASE_INC_RESET  = '0;
   localparam logic                    WRAP_MODE_RESET  = 1'b0;

   // wrap modes
   localparam logic WRAP_CONTINUOUS    = 1'b0;
   localparam logic WRAP_DISCONTINUOUS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_RD_CUR,
      ST_RD_NEXT,
      ST_RD_ALT,
      ST_MUL,
      ST_OUT
   } osc_state_type;

endpackage

FILE: sv/wio_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wio_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/wio_mod.sv
// Bit-serial restoring modulo unit: remainder of dividend by divisor,
// one dividend bit per cycle. Depends on nothing.
`timescale 1ns / 1ps

module wio_mod #(
   parameter int VAL_W = 7,
   parameter int DIV_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(VAL_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   trial;

   // shift next dividend bit into the partial remainder
   assign trial = {rem_ff, val_ff[VAL_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VAL_W);
         val_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[VAL_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIV_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/wavetable_interpolating_oscillator_core.sv
// Top level of the wavetable oscillator with linear interpolation.
// Depends on wio_pkg, wio_ram and wio_mod.
`timescale 1ns / 1ps

// Usage
// - Request channel (req_*): op selects a tick or a table write. A write stores
//   entry_value at entry_index (indexes at or above TABLE_DEPTH are dropped)
//   and yields no response. A tick advances the phase (5.16 at the defaults)
//   and yields exactly one response carrying the interpolated sample.
// - Response channel (rsp_*): valid/ready; one output register holds the
//   sample, so a waiting response does not block new requests.
// - CSR port: csr_we/csr_index/csr_wdata write table_size, phase_increment and
//   wrap_mode. Write only while no tick is in flight.
// - Sequence: after a tick is accepted, the position wrap runs one bit per
//   cycle in wio_mod over the VW-bit dividend (VW is 7 at the defaults); then
//   three reads through the single read port of the table RAM and one
//   multiply follow before rsp_valid rises.
// - Throughput: a new tick is taken only once the last one has left ST_OUT;
//   one write per cycle while idle. req_ready is high only between ticks.
// - Reset: position and fraction clear, registers take their reset values.
//   Table contents are not cleared; read only entries already written.
// - Stall: if rsp_ready stays low, a finished tick waits in its last state
//   until the output register frees; writes are still taken meanwhile only
//   when no tick is pending.
module wavetable_interpolating_oscillator_core #(
   parameter int TABLE_DEPTH   = wio_pkg::DEF_TABLE_DEPTH,
   parameter int FRACTION_BITS = wio_pkg::DEF_FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wio_pkg::OP_W-1:0]              req_op,
   input  logic [wio_pkg::INDEX_W-1:0]           req_entry_index,
   input  logic signed [wio_pkg::SAMPLE_W-1:0]   req_entry_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [wio_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                  csr_we,
   input  logic [wio_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wio_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   import wio_pkg::*;

   localparam int PW  = $clog2(TABLE_DEPTH);          // table address width
   localparam int EW  = $clog2(TABLE_DEPTH + 1);      // effective size width
   localparam int SW  = ((INC_W > FRACTION_BITS) ? INC_W : FRACTION_BITS) + 1;
   localparam int CW  = SW - FRACTION_BITS;           // integer carry width
   localparam int VW  = ((PW > CW) ? PW : CW) + 1;    // modulo dividend width
   localparam int PRW = SAMPLE_W + 2 + FRACTION_BITS; // slope * fraction

   // configuration registers
   logic [TABLE_SIZE_W-1:0] table_size_ff;
   logic [INC_W-1:0]        phase_inc_ff;
   logic                    wrap_mode_ff;

   // oscillator state and pipeline registers
   osc_state_type             state_ff, state_in;
   logic [PW-1:0]             pos_ff;
   logic [FRACTION_BITS-1:0]  frac_ff;
   logic signed [SAMPLE_W-1:0] cur_ff;
   logic signed [SAMPLE_W-1:0] opb_ff;
   logic signed [PRW-1:0]     prod_ff, prod_in;
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   // control
   logic          accept;
   logic          mod_start;
   logic          mod_done;
   logic [EW-1:0] mod_rem;
   logic          cur_load, opb_load, prod_load, out_load, out_free;
   logic [PW-1:0] ram_raddr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic          ram_we;
   logic [PW-1:0] ram_waddr;

   // datapath helpers
   logic [31:0]            size_full;
   logic [31:0]            index_full;
   logic [EW-1:0]          size_eff;
   logic [SW-1:0]          phase_sum;
   logic [CW-1:0]          carry;
   logic [VW-1:0]          dividend;
   logic                   at_last;
   logic                   slope_alt;
   logic [PW-1:0]          next_addr;
   logic signed [SAMPLE_W-1:0] op_a, op_b;
   logic signed [SAMPLE_W:0]   slope;
   logic signed [FRACTION_BITS:0] frac_s;
   logic signed [PRW-1:0]  shifted;

   // ---------------------------------------------------------------- CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
         phase_inc_ff  <= PHASE_INC_RESET;
         wrap_mode_ff  <= WRAP_MODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_SIZE: table_size_ff <= csr_wdata[TABLE_SIZE_W-1:0];
            CSR_PHASE_INC:  phase_inc_ff  <= csr_wdata[INC_W-1:0];
            CSR_WRAP_MODE:  wrap_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective table size: clamp to [2, TABLE_DEPTH]
   always_comb begin
      if (32'(table_size_ff) < 32'd2) begin
         size_full = 32'd2;
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         size_full = 32'(TABLE_DEPTH);
      end else begin
         size_full = 32'(table_size_ff);
      end
   end
   assign size_eff = size_full[EW-1:0];

   // ---------------------------------------------------------------- phase
   assign phase_sum = SW'(phase_inc_ff) + SW'(frac_ff);
   assign carry     = phase_sum[SW-1:FRACTION_BITS];
   assign dividend  = VW'(pos_ff) + VW'(carry);

   // ---------------------------------------------------------------- table
   assign accept     = req_valid && req_ready;
   assign index_full = 32'(req_entry_index);
   assign ram_we     = accept && (req_op == OP_WRITE) && (index_full < 32'(TABLE_DEPTH));
   assign ram_waddr  = index_full[PW-1:0];

   wio_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_entry_value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wio_mod #(
      .VAL_W (VW),
      .DIV_W (EW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (dividend),
      .divisor   (size_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // neighbor selection at the last entry
   assign at_last   = 32'(pos_ff) == (32'(size_eff) - 32'd1);
   assign slope_alt = at_last && (wrap_mode_ff == WRAP_DISCONTINUOUS);
   assign next_addr = at_last ? '0 : pos_ff + PW'(1);

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_op == OP_TICK)) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_RD_CUR;
            end
         end
         ST_RD_CUR:  state_in = ST_RD_NEXT;
         ST_RD_NEXT: state_in = ST_RD_ALT;
         ST_RD_ALT:  state_in = ST_MUL;
         ST_MUL:     state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      req_ready = 1'b0;
      mod_start = 1'b0;
      ram_raddr = pos_ff;
      cur_load  = 1'b0;
      opb_load  = 1'b0;
      prod_load = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            mod_start = req_valid && (req_op == OP_TICK);
         end
         ST_MOD:    ;
         ST_RD_CUR: ram_raddr = pos_ff;
         ST_RD_NEXT: begin
            ram_raddr = next_addr;   // entry 0 when wrapping
            cur_load  = 1'b1;
         end
         ST_RD_ALT: begin
            ram_raddr = PW'(1);      // only used in discontinuous wrap
            opb_load  = 1'b1;
         end
         ST_MUL:    prod_load = 1'b1;
         ST_OUT:    out_load  = out_free;
         default:   ;
      endcase
   end

   // ---------------------------------------------------------------- math
   // discontinuous wrap: slope = entry[0] - entry[1]
   assign op_a    = slope_alt ? opb_ff : cur_ff;
   assign op_b    = slope_alt ? $signed(ram_rdata) : opb_ff;
   assign slope   = {op_a[SAMPLE_W-1], op_a} - {op_b[SAMPLE_W-1], op_b};
   assign frac_s  = {1'b0, frac_ff};
   assign prod_in = slope * frac_s;

   // arithmetic shift floors toward minus infinity
   assign shifted     = prod_ff >>> FRACTION_BITS;
   assign rsp_data_in = cur_ff - shifted[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mod_start) begin
            frac_ff <= phase_sum[FRACTION_BITS-1:0];
         end
         if (mod_done) begin
            pos_ff <= mod_rem[PW-1:0];
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cur_load) begin
         cur_ff <= ram_rdata;
      end
      if (opb_load) begin
         opb_ff <= ram_rdata;
      end
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

FILE: sv/wio_checker.sv
// Port-level checks for the wavetable oscillator core, bound to the top level.
// Depends on wio_pkg and wavetable_interpolating_oscillator_core.
`timescale 1ns / 1ps

module wio_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [wio_pkg::OP_W-1:0]            req_op,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [wio_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   import wio_pkg::*;

   // a tick request holds off further requests while it is computed
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == OP_TICK)) |=> !req_ready)
      else $error("request accepted right after a tick");

   // a table write never produces a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == OP_WRITE) && !rsp_valid) |=> !rsp_valid)
      else $error("response after a table write");

   // a new response only appears while a tick was being worked on
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a tick in flight");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))
      else $error("stalled response changed");

endmodule

bind wavetable_interpolating_oscillator_core wio_checker u_wio_checker (.*);
